// ===== hdl/lru_bucket_cache_manager_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lru_bucket_cache_manager_unit_defines
// Assertion macros shared by the cache manager RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_BUCKET_CACHE_MANAGER_UNIT_DEFINES_SVH
`define LRU_BUCKET_CACHE_MANAGER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LBCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LBCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbcm_pkg
// Types, constants and helpers of the LRU bucket cache manager.
// ----------------------------------------------------------------------------
package lbcm_pkg;

  localparam int BUCKETS = 4096;
  localparam int DEPTH   = BUCKETS + 1;
  localparam int IDX_W   = 13;
  localparam int KB_W    = 15;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 28;
  localparam int MB_W    = 17;
  localparam int BUDGET_W = 12;
  localparam int RCNT_W  = 6;
  localparam int EXP_W   = 21;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_MAX_MB = 2'd0;
  localparam logic [1:0] REG_RCOUNT = 2'd1;
  localparam logic [1:0] REG_EXPIRE = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  next;
    logic              used;
    logic [KB_W-1:0]   size;
    logic [TIME_W-1:0] stime;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EVAL, ST_SEL, ST_RMW_RD, ST_RMW_WR, ST_WR_B,
    ST_ACC_EMIT, ST_EV_RD, ST_EV_WR, ST_EV_EMIT, ST_EV_HRD, ST_EV_HWR
  } state_e;

  // Used memory in MB, saturated to the width of the result field.
  function automatic logic [MB_W-1:0] used_mb(input logic [TOTAL_W-1:0] t);
    logic [TOTAL_W-11:0] mb;
    mb = t[TOTAL_W-1:10];
    used_mb = (mb > (TOTAL_W-10)'({MB_W{1'b1}})) ? {MB_W{1'b1}} : mb[MB_W-1:0];
  endfunction

  // Total less one size, floored at zero.
  function automatic logic [TOTAL_W-1:0] sub_sat(input logic [TOTAL_W-1:0] t,
                                                 input logic [KB_W-1:0] s);
    logic [TOTAL_W-1:0] se;
    se = TOTAL_W'(s);
    sub_sat = (t >= se) ? t - se : '0;
  endfunction

endpackage

// ===== hdl/lbcm_ram.sv =====
// ----------------------------------------------------------------------------
// lbcm_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/lru_bucket_cache_manager_unit.sv =====
// ----------------------------------------------------------------------------
// lru_bucket_cache_manager_unit
// LRU bucket cache manager: freshness check, refill and budget eviction.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_ready  | bucket, now, entry_kb
//  out     | output    | out_valid/out_ready| kind, bucket_out, fresh_hit,
//          |           |                    | used_mb, last
//  cfg     | input     | APB psel/penable   | max_memory_mb, remove_count,
//          |           |                    | expire_seconds
//
// An access is the entry read, one read-modify-write (select, read, write)
// of the table for each neighbor link that changes (up to three), the
// write-back of the bucket and the report. Each evicted bucket adds the
// dependent read and clear of the old head, its report and the read and
// write that clear the new head's prev link (not needed when it empties the
// list). After reset a clearing pass zeroes all 4097 table entries, during
// which no word is accepted; configuration writes work at all times.
// A stalled output holds the sequencer in its report state.
//
// All per-bucket state (links, in-use mark, size, store time) lives in one
// table word, so each step of the list update is one read and one write.
// The block works on one word at a time, so accesses never overlap.
module lru_bucket_cache_manager_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lbcm_pkg::IDX_W-1:0]    bucket_i,
  input  logic [lbcm_pkg::TIME_W-1:0]   now_i,
  input  logic [lbcm_pkg::KB_W-1:0]     entry_kb_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [lbcm_pkg::IDX_W-1:0]    bucket_out_o,
  output logic                          fresh_hit_o,
  output logic [lbcm_pkg::MB_W-1:0]     used_mb_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lbcm_pkg::*;

  `include "lru_bucket_cache_manager_unit_defines.svh"

  state_e state_q, state_d;

  // Configuration registers.
  logic [BUDGET_W-1:0] max_mb_q;
  logic [RCNT_W-1:0]   rc_q;
  logic [EXP_W-1:0]    exp_q;

  // Access context.
  logic [IDX_W-1:0]  b_q, b_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [KB_W-1:0]   kb_q, kb_d;
  logic              oor_q, oor_d;
  logic              fresh_q, fresh_d;
  entry_t            ent_q, ent_d;

  // Pending link updates: next of p, prev of n, prev of new head, next of old tail.
  logic [3:0]        pend_q, pend_d;
  logic [IDX_W-1:0]  p_q, p_d, n_q, n_d, h_q, h_d, t_q, t_d;
  logic [IDX_W-1:0]  rmw_addr_q, rmw_addr_d, rmw_val_q, rmw_val_d;
  logic              rmw_prev_q, rmw_prev_d;

  // List and budget state.
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // Eviction.
  logic [RCNT_W-1:0] ev_cnt_q, ev_cnt_d;
  logic              ev_last_q, ev_last_d;
  logic [IDX_W-1:0]  d_q, d_d;
  logic [IDX_W-1:0]  clr_q, clr_d;

  // Output register.
  logic              ov_q, ov_d;
  logic              kind_q, kind_d, ofresh_q, ofresh_d, last_q, last_d;
  logic [IDX_W-1:0]  obkt_q, obkt_d;
  logic [MB_W-1:0]   omb_q, omb_d;

  // Table port.
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  logic cfg_wr, out_free, in_fire, ev_go;

  lbcm_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_MB: prdata = 32'(max_mb_q);
      REG_RCOUNT: prdata = 32'(rc_q);
      REG_EXPIRE: prdata = 32'(exp_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mb_q <= BUDGET_W'(256);
      rc_q     <= RCNT_W'(63);
      exp_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_MB: max_mb_q <= pwdata[BUDGET_W-1:0];
        REG_RCOUNT: rc_q     <= pwdata[RCNT_W-1:0];
        REG_EXPIRE: exp_q    <= pwdata[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = !ov_q || out_ready_i;

  // Eviction: used MB over budget, list not empty, remove count set, bucket valid.
  assign ev_go = !oor_q && (total_q[TOTAL_W-1:10] > (TOTAL_W-10)'(max_mb_q)) &&
                 (head_q != '0) && (tail_q != '0) && (rc_q != '0);

  always_comb begin
    entry_t             e;
    logic               fr;
    logic signed [TIME_W:0] age;
    logic [TOTAL_W:0]   sum;

    state_d = state_q;
    b_d = b_q; now_d = now_q; kb_d = kb_q; oor_d = oor_q; fresh_d = fresh_q;
    ent_d = ent_q; pend_d = pend_q;
    p_d = p_q; n_d = n_q; h_d = h_q; t_d = t_q;
    rmw_addr_d = rmw_addr_q; rmw_val_d = rmw_val_q; rmw_prev_d = rmw_prev_q;
    head_d = head_q; tail_d = tail_q; total_d = total_q;
    ev_cnt_d = ev_cnt_q; ev_last_d = ev_last_q; d_d = d_q; clr_d = clr_q;
    ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; ofresh_d = ofresh_q; last_d = last_q;
    obkt_d = obkt_q; omb_d = omb_q;
    we = 1'b0; waddr = b_q; wdata = rdata; raddr = b_q;
    e = rdata; fr = 1'b0; age = '0; sum = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(BUCKETS)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = bucket_i;
        if (in_fire) begin
          b_d     = bucket_i;
          now_d   = now_i;
          kb_d    = entry_kb_i;
          fresh_d = 1'b0;
          oor_d   = (bucket_i == '0) || (bucket_i > IDX_W'(BUCKETS));
          state_d = oor_d ? ST_ACC_EMIT : ST_EVAL;
        end
      end
      ST_EVAL: begin
        // A negative age counts as inside the window.
        age = $signed({1'b0, now_q}) - $signed({1'b0, rdata.stime});
        fr  = rdata.used && (exp_q != '0) &&
              (age <= $signed({{(TIME_W+1-EXP_W){1'b0}}, exp_q}));
        fresh_d = fr;
        if (!fr) begin
          sum = {1'b0, sub_sat(total_q, rdata.size)} + (TOTAL_W+1)'(kb_q);
          total_d = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
          e.used  = 1'b1;
          e.size  = kb_q;
          e.stime = now_q;
        end
        pend_d = '0;
        t_d    = tail_q;
        p_d    = rdata.prev;
        n_d    = rdata.next;
        h_d    = rdata.next;
        if (head_q == '0 || tail_q == '0) begin
          e.prev = '0;
          e.next = '0;
          head_d = b_q;
          tail_d = b_q;
        end else if (b_q == tail_q) begin
          // Already most recent.
        end else begin
          if (b_q == head_q) begin
            head_d    = rdata.next;
            pend_d[2] = 1'b1;
          end else if (rdata.prev != '0 && rdata.next != '0) begin
            pend_d[1:0] = 2'b11;
          end
          pend_d[3] = 1'b1;
          e.prev    = tail_q;
          e.next    = '0;
          tail_d    = b_q;
        end
        ent_d   = e;
        state_d = ST_SEL;
      end
      ST_SEL: begin
        state_d = ST_RMW_RD;
        priority if (pend_q[0]) begin
          rmw_addr_d = p_q; rmw_prev_d = 1'b0; rmw_val_d = n_q; pend_d[0] = 1'b0;
        end else if (pend_q[1]) begin
          rmw_addr_d = n_q; rmw_prev_d = 1'b1; rmw_val_d = p_q; pend_d[1] = 1'b0;
        end else if (pend_q[2]) begin
          rmw_addr_d = h_q; rmw_prev_d = 1'b1; rmw_val_d = '0; pend_d[2] = 1'b0;
        end else if (pend_q[3]) begin
          rmw_addr_d = t_q; rmw_prev_d = 1'b0; rmw_val_d = b_q; pend_d[3] = 1'b0;
        end else begin
          state_d = ST_WR_B;
        end
      end
      ST_RMW_RD: begin
        raddr   = rmw_addr_q;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        e = rdata;
        if (rmw_prev_q) begin
          e.prev = rmw_val_q;
        end else begin
          e.next = rmw_val_q;
        end
        we      = 1'b1;
        waddr   = rmw_addr_q;
        wdata   = e;
        state_d = ST_SEL;
      end
      ST_WR_B: begin
        we      = 1'b1;
        waddr   = b_q;
        wdata   = ent_q;
        state_d = ST_ACC_EMIT;
      end
      ST_ACC_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          kind_d   = 1'b0;
          obkt_d   = b_q;
          ofresh_d = fresh_q;
          omb_d    = used_mb(total_q);
          last_d   = !ev_go;
          ev_cnt_d = '0;
          state_d  = ev_go ? ST_EV_RD : ST_IDLE;
        end
      end
      ST_EV_RD: begin
        raddr   = head_q;
        state_d = ST_EV_WR;
      end
      ST_EV_WR: begin
        we      = 1'b1;
        waddr   = head_q;
        wdata   = '0;
        d_d     = head_q;
        head_d  = rdata.next;
        total_d = sub_sat(total_q, rdata.size);
        if (rdata.next == '0) begin
          // List emptied.
          tail_d    = '0;
          total_d   = '0;
          ev_last_d = 1'b1;
        end else begin
          ev_last_d = (ev_cnt_q == rc_q - 1'b1);
        end
        state_d = ST_EV_EMIT;
      end
      ST_EV_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          kind_d   = 1'b1;
          obkt_d   = d_q;
          ofresh_d = 1'b0;
          omb_d    = used_mb(total_q);
          last_d   = ev_last_q;
          state_d  = (head_q == '0) ? ST_IDLE : ST_EV_HRD;
        end
      end
      ST_EV_HRD: begin
        raddr   = head_q;
        state_d = ST_EV_HWR;
      end
      ST_EV_HWR: begin
        e       = rdata;
        e.prev  = '0;
        we      = 1'b1;
        waddr   = head_q;
        wdata   = e;
        ev_cnt_d = ev_cnt_q + 1'b1;
        state_d = ev_last_q ? ST_IDLE : ST_EV_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      total_q  <= '0;
      ov_q     <= 1'b0;
      pend_q   <= '0;
      ev_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      total_q  <= total_d;
      ov_q     <= ov_d;
      pend_q   <= pend_d;
      ev_cnt_q <= ev_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d; now_q <= now_d; kb_q <= kb_d; oor_q <= oor_d; fresh_q <= fresh_d;
    ent_q <= ent_d;
    p_q <= p_d; n_q <= n_d; h_q <= h_d; t_q <= t_d;
    rmw_addr_q <= rmw_addr_d; rmw_val_q <= rmw_val_d; rmw_prev_q <= rmw_prev_d;
    ev_last_q <= ev_last_d; d_q <= d_d;
    kind_q <= kind_d; ofresh_q <= ofresh_d; last_q <= last_d;
    obkt_q <= obkt_d; omb_q <= omb_d;
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign bucket_out_o = obkt_q;
  assign fresh_hit_o  = ofresh_q;
  assign used_mb_o    = omb_q;
  assign last_o       = last_q;

  // Head and tail are empty together whenever the block waits for a word.
  `LBCM_ASSERT_IMP(a_head_tail, state_q == ST_IDLE, (head_q == '0) == (tail_q == '0), "ends")
  // No report leaves during the clearing pass.
  `LBCM_ASSERT_IMP(a_clear_quiet, state_q == ST_CLEAR, !ov_q, "report during clear")
  // The eviction count stays below the limit.
  `LBCM_ASSERT_IMP(a_ev_bound, state_q == ST_EV_WR, ev_cnt_q < rc_q, "eviction overrun")
  // An accepted word keeps the block busy in the next cycle.
  `LBCM_ASSERT_NXT(a_busy, in_fire, !in_ready_o, "accepted while busy")

endmodule

// ===== dv/lru_bucket_cache_manager_unit_test.sv =====
// ----------------------------------------------------------------------------
// lru_bucket_cache_manager_unit_test
// Self-checking testbench of the LRU bucket cache manager.
// ----------------------------------------------------------------------------
//
// A queued driver offers access words with random gaps. A monitor takes the
// report words with random stalls, and once with one long hold-off. Each
// accepted access runs through a local model of the LRU list, the refill
// bookkeeping and the budget eviction. The reports it predicts are queued and
// compared field by field with the words that come out of the block. The
// registers are rewritten between phases, only once the block has gone idle.
module lru_bucket_cache_manager_unit_test;
  import lbcm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  bucket;
    logic [TIME_W-1:0] now;
    logic [KB_W-1:0]   kb;
  } access_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] bucket;
    logic             fresh;
    logic [MB_W-1:0]  used;
    logic             last;
  } report_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 50;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [IDX_W-1:0]    bucket_i = '0;
  logic [TIME_W-1:0]   now_i = '0;
  logic [KB_W-1:0]     entry_kb_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                kind_o;
  logic [IDX_W-1:0]    bucket_out_o;
  logic                fresh_hit_o;
  logic [MB_W-1:0]     used_mb_o;
  logic                last_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  lru_bucket_cache_manager_unit i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Local copy of the cache state and the registers.
  logic [IDX_W-1:0]    lru_prev [0:BUCKETS];
  logic [IDX_W-1:0]    lru_next [0:BUCKETS];
  logic                live     [0:BUCKETS];
  logic [TIME_W-1:0]   stamp    [0:BUCKETS];
  logic [KB_W-1:0]     held_kb  [0:BUCKETS];
  logic [IDX_W-1:0]    lru_head;
  logic [IDX_W-1:0]    lru_tail;
  longint              used_kb;
  logic [BUDGET_W-1:0] budget_mb;
  logic [RCNT_W-1:0]   evict_max;
  logic [EXP_W-1:0]    expire_s;

  access_t access_q[$];
  report_t report_q[$];
  int      mismatches;
  bit      no_idle;
  bit      hold_req;
  bit      holding;

  function automatic logic [MB_W-1:0] mb_of_total();
    longint mb;
    mb = used_kb >> 10;
    return (mb > 131071) ? MB_W'(131071) : MB_W'(mb);
  endfunction

  function automatic void push_report(logic kind, logic [IDX_W-1:0] b, logic fresh);
    report_t r;
    r.kind = kind;
    r.bucket = b;
    r.fresh = fresh;
    r.used = mb_of_total();
    r.last = 1'b0;
    report_q.push_back(r);
  endfunction

  function automatic void link_at_tail(logic [IDX_W-1:0] b);
    lru_prev[b] = lru_tail;
    lru_next[b] = '0;
    lru_next[lru_tail] = b;
    lru_tail = b;
  endfunction

  // Moves a bucket to the most recent end of the list.
  function automatic void move_to_tail(logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    if (lru_head == 0 || lru_tail == 0) begin
      lru_prev[b] = '0;
      lru_next[b] = '0;
      lru_head = b;
      lru_tail = b;
    end else if (b == lru_tail) begin
    end else if (b == lru_head) begin
      lru_head = lru_next[b];
      lru_prev[lru_head] = '0;
      link_at_tail(b);
    end else begin
      p = lru_prev[b];
      n = lru_next[b];
      // A bucket with one zero link off both ends is treated as unlinked.
      if (p != 0 && n != 0) begin
        lru_next[p] = n;
        lru_prev[n] = p;
      end
      link_at_tail(b);
    end
  endfunction

  // Works out every report that one accepted access causes.
  function automatic void predict_access(access_t a);
    logic             fresh;
    longint           age;
    logic [IDX_W-1:0] d;
    report_t          r;
    fresh = 1'b0;
    if (a.bucket == 0 || a.bucket > BUCKETS) begin
      push_report(1'b0, a.bucket, 1'b0);
    end else begin
      if (live[a.bucket] && expire_s != 0) begin
        // Signed age, so time going backwards counts as fresh.
        age = longint'(a.now) - longint'(stamp[a.bucket]);
        if (age <= longint'(expire_s)) fresh = 1'b1;
      end
      if (!fresh) begin
        used_kb = (used_kb >= held_kb[a.bucket]) ? used_kb - held_kb[a.bucket] : 0;
        used_kb += a.kb;
        if (used_kb > 28'hFFFFFFF) used_kb = 28'hFFFFFFF;
        held_kb[a.bucket] = a.kb;
        stamp[a.bucket] = a.now;
        live[a.bucket] = 1'b1;
      end
      move_to_tail(a.bucket);
      push_report(1'b0, a.bucket, fresh);
      if ((used_kb >> 10) > budget_mb && lru_head != 0 && lru_tail != 0) begin
        for (int i = 0; i < evict_max; i++) begin
          d = lru_head;
          lru_head = lru_next[d];
          used_kb = (used_kb >= held_kb[d]) ? used_kb - held_kb[d] : 0;
          lru_next[d] = '0;
          lru_prev[d] = '0;
          live[d] = 1'b0;
          held_kb[d] = '0;
          stamp[d] = '0;
          if (lru_head == 0) begin
            // The list ran empty, so nothing is left in use.
            lru_tail = '0;
            used_kb = 0;
            push_report(1'b1, d, 1'b0);
            break;
          end
          lru_prev[lru_head] = '0;
          push_report(1'b1, d, 1'b0);
        end
      end
    end
    r = report_q.pop_back();
    r.last = 1'b1;
    report_q.push_back(r);
  endfunction

  // Driver: one word at a time from the queue, with a drawn gap after each.
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    access_t nxt;
    bit      busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_access('{bucket: bucket_i, now: now_i, kb: entry_kb_i});
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (access_q.size() > 0) begin
          nxt = access_q.pop_front();
          bucket_i <= nxt.bucket;
          now_i <= nxt.now;
          entry_kb_i <= nxt.kb;
          in_valid_i <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off, counted on its own.
  int hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      holding <= 1'b0;
    end else if (hold_req && !holding && hold_cnt == 0) begin
      holding <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (holding) begin
      if (hold_cnt == 1) holding <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: takes report words and checks them against the oldest prediction.
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    report_t want;
    int      gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = recv_gap;
      if (out_valid_o && out_ready_i) begin
        got = '{kind: kind_o, bucket: bucket_out_o, fresh: fresh_hit_o,
                used: used_mb_o, last: last_o};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected report word: %p", got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Report mismatch: expected %p, got %p", want, got);
          end
        end
        gap = no_idle ? 0 : $urandom_range(0, 7);
      end else if (gap > 0) begin
        gap--;
      end
      recv_gap <= gap;
      out_ready_i <= (gap == 0) && !holding && !(hold_req && hold_cnt == 0);
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_MB: budget_mb = val[BUDGET_W-1:0];
      REG_RCOUNT: evict_max = val[RCNT_W-1:0];
      default:    expire_s = val[EXP_W-1:0];
    endcase
  endtask

  task automatic set_regs(int mb, int rc, int ex);
    reg_write(REG_MAX_MB, mb);
    reg_write(REG_RCOUNT, rc);
    reg_write(REG_EXPIRE, ex);
  endtask

  task automatic queue_access(int b, logic [31:0] t, int kb);
    access_q.push_back('{bucket: IDX_W'(b), now: t, kb: KB_W'(kb)});
  endtask

  // Waits for all words to drain, then lets the block settle.
  task automatic drain();
    while (access_q.size() > 0 || in_valid_i || report_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random accesses: mostly a small hot set, so the list, hits and
  // evictions stay busy, with some wide and out-of-range buckets as noise.
  task automatic queue_random(int count, logic [31:0] base);
    int          b;
    int          kb;
    int          pick;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       b = $urandom_range(0, 1) ? 0 : $urandom_range(BUCKETS + 1, 8191);
      else if (pick < 12) b = $urandom_range(1, BUCKETS);
      else                b = $urandom_range(1, 20);
      pick = $urandom_range(0, 9);
      if (pick < 2) t = $urandom();
      else          t = base + $urandom_range(0, 400) - 100;
      base += $urandom_range(0, 20);
      pick = $urandom_range(0, 9);
      if (pick < 5)      kb = $urandom_range(1, 4095);
      else if (pick < 9) kb = $urandom_range(1, 32767);
      else               kb = $urandom_range(0, 1) ? 32767 : 1;
      queue_access(b, t, kb);
    end
  endtask

  initial begin
    for (int i = 0; i <= BUCKETS; i++) begin
      lru_prev[i] = '0;
      lru_next[i] = '0;
      live[i] = 1'b0;
      stamp[i] = '0;
      held_kb[i] = '0;
    end
    lru_head = '0;
    lru_tail = '0;
    used_kb = 0;
    budget_mb = 12'd256;
    evict_max = 6'd63;
    expire_s = '0;
    mismatches = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings: range ends, a stale repeat.
    queue_access(1, 32'd1000, 32767);
    queue_access(1, 32'd1001, 1);
    queue_access(0, 32'd0, 5);
    queue_access(8191, 32'hFFFFFFFF, 32767);
    queue_access(BUCKETS + 1, 32'd7, 100);
    drain();

    // Fresh hits, time going backwards, head and middle moves.
    set_regs(4095, 63, 100);
    queue_access(2, 32'd1000, 2000);
    queue_access(3, 32'd1000, 3000);
    queue_access(1, 32'd1050, 4000);
    queue_access(2, 32'd10, 5000);
    queue_access(3, 32'd2000, 6000);
    queue_access(BUCKETS, 32'hFFFFFFFF, 32767);
    queue_access(BUCKETS, 32'd0, 16384);
    queue_access(2, 32'd1100, 1);
    drain();

    // Zero budget empties the list; single and zero evictions per access.
    set_regs(0, 63, 1966020);
    queue_access(5, 32'd0, 32767);
    queue_access(6, 32'd5, 1024);
    queue_access(7, 32'd6, 1023);
    drain();
    set_regs(0, 1, 1966020);
    queue_access(8, 32'd9, 2048);
    queue_access(9, 32'd9, 2048);
    queue_access(10, 32'd9, 512);
    drain();

    // Random phases through several register settings.
    set_regs(1, 1, 1966020);
    queue_random(80, 32'd5000);
    drain();
    set_regs(4095, 0, 0);
    no_idle = 1'b1;
    queue_random(60, 32'hFFFFFF00);
    drain();
    no_idle = 1'b0;
    set_regs(0, 0, 300);
    queue_random(40, 32'd100);
    drain();
    set_regs(2, 7, 300);
    queue_random(90, 32'd90000);
    drain();
    // Hold the receiver off while the sender keeps offering words.
    set_regs(20, 63, 1000);
    hold_req = 1'b1;
    queue_random(70, 32'd700000);
    wait (holding);
    hold_req = 1'b0;
    drain();
    set_regs(8, 3, 50);
    queue_random(70, 32'd12345);
    drain();

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lbcm_pkg.sv
hdl/lbcm_ram.sv
hdl/lru_bucket_cache_manager_unit.sv
dv/lru_bucket_cache_manager_unit_test.sv
